// ----- src/rmsb_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rmsb_pkg
// widths, defaults and the job record shared by the rms block modules
// ----------------------------------------------------------------------------
package rmsb_pkg;

  localparam int SAMPLE_W = 17;
  localparam int MAG_W    = 17;
  localparam int SQ_W     = 33;
  localparam int SUM_W    = 40;
  localparam int COUNT_W  = 8;
  localparam int RMS_W    = 16;
  localparam int ROOT_W   = 17;
  localparam int RAD_W    = 34;
  localparam int SREM_W   = 18;

  localparam int DEFAULT_MAX_SAMPLES     = 64;
  localparam int DEFAULT_SKIPPED_SAMPLES = 2;

  localparam int JOB_DEPTH = 2;
  localparam int JOB_PTR_W = $clog2(JOB_DEPTH);
  localparam int LEVEL_W   = $clog2(JOB_DEPTH + 1);

  localparam int DIV_STEPS  = SUM_W;
  localparam int SQRT_STEPS = ROOT_W;
  localparam int STEP_W     = $clog2(DIV_STEPS);

  typedef struct packed {
    logic [SUM_W-1:0]   sum;
    logic [COUNT_W-1:0] count;
  } job_t;

endpackage
`default_nettype wire

// ----- src/rms_of_sample_block.sv -----
`default_nettype none
// path: a result follows its last accepted sample through the intake register, the job
//   queue, 40 divide steps, 17 root steps and the load of the result register
// throughput: one sample per cycle while full is low; one block is solved at a time in
//   the serial divider and root unit, with two blocks queued ahead
// reset: synchronous, clears the running sum, count, job queue and result valid
// ----------------------------------------------------------------------------
// rms_of_sample_block
// rms over a block of signed samples, with the first samples left out of the sum
// ----------------------------------------------------------------------------
module rms_of_sample_block #(
  parameter int MAX_SAMPLES     = rmsb_pkg::DEFAULT_MAX_SAMPLES,
  parameter int SKIPPED_SAMPLES = rmsb_pkg::DEFAULT_SKIPPED_SAMPLES
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 push,
  output logic                                      full,
  input  wire logic signed [rmsb_pkg::SAMPLE_W-1:0] sample_value,
  input  wire logic                                 last_sample,
  output logic                                      empty,
  input  wire logic                                 pop,
  output logic [rmsb_pkg::RMS_W-1:0]                rms_value,
  output logic [rmsb_pkg::COUNT_W-1:0]              sample_count
);
  import rmsb_pkg::*;

  logic               job_wr;
  job_t               job_wdata;
  logic               job_rd;
  job_t               job_rdata;
  logic               job_empty;
  logic [LEVEL_W-1:0] job_level;

  rmsb_front #(
    .MAX_SAMPLES     (MAX_SAMPLES),
    .SKIPPED_SAMPLES (SKIPPED_SAMPLES)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .sample_value (sample_value),
    .last_sample  (last_sample),
    .job_level    (job_level),
    .job_wr       (job_wr),
    .job_data     (job_wdata)
  );

  rmsb_job_fifo u_fifo (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (job_wr),
    .wr_data (job_wdata),
    .rd_en   (job_rd),
    .rd_data (job_rdata),
    .empty   (job_empty),
    .level   (job_level)
  );

  rmsb_back u_back (
    .clk          (clk),
    .rst          (rst),
    .job_empty    (job_empty),
    .job_data     (job_rdata),
    .job_rd       (job_rd),
    .empty        (empty),
    .pop          (pop),
    .rms_value    (rms_value),
    .sample_count (sample_count)
  );

endmodule
`default_nettype wire

// ----- src/rmsb_job_fifo.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rmsb_job_fifo
// short register queue of finished sums between accumulator and solver
// ----------------------------------------------------------------------------
module rmsb_job_fifo (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          wr_en,
  input  wire rmsb_pkg::job_t                wr_data,
  input  wire logic                          rd_en,
  output rmsb_pkg::job_t                     rd_data,
  output logic                               empty,
  output logic [rmsb_pkg::LEVEL_W-1:0]       level
);
  import rmsb_pkg::*;

  job_t                 entries [JOB_DEPTH];
  logic [JOB_PTR_W-1:0] wptr;
  logic [JOB_PTR_W-1:0] rptr;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      entries[wptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      level <= '0;
    end else begin
      if (wr_en) begin
        wptr <= (wptr == JOB_PTR_W'(JOB_DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (rd_en) begin
        rptr <= (rptr == JOB_PTR_W'(JOB_DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (wr_en && !rd_en) begin
        level <= level + 1'b1;
      end else if (!wr_en && rd_en) begin
        level <= level - 1'b1;
      end
    end
  end

  assign rd_data = entries[rptr];
  assign empty   = (level == '0);

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> (level != LEVEL_W'(JOB_DEPTH)))
    else $error("job queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    rd_en |-> (level != '0))
    else $error("job queue read while empty");
`endif

endmodule
`default_nettype wire

// ----- src/rmsb_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rmsb_front
// sample intake: count, square and accumulate, hand a job on the last sample
// ----------------------------------------------------------------------------
module rmsb_front #(
  parameter int MAX_SAMPLES     = rmsb_pkg::DEFAULT_MAX_SAMPLES,
  parameter int SKIPPED_SAMPLES = rmsb_pkg::DEFAULT_SKIPPED_SAMPLES
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          push,
  output logic                               full,
  input  wire logic signed [rmsb_pkg::SAMPLE_W-1:0] sample_value,
  input  wire logic                          last_sample,
  input  wire logic [rmsb_pkg::LEVEL_W-1:0]  job_level,
  output logic                               job_wr,
  output rmsb_pkg::job_t                     job_data
);
  import rmsb_pkg::*;

  logic                 accept;
  logic                 counted;
  logic                 squared;
  logic [MAG_W-1:0]     mag;
  logic [2*MAG_W-1:0]   sq_full;
  logic [LEVEL_W:0]     need;

  logic [COUNT_W-1:0]   seen;
  logic [COUNT_W-1:0]   seen_next;
  logic                 s1_valid;
  logic                 s1_last;
  logic [SQ_W-1:0]      s1_sq;
  logic [COUNT_W-1:0]   s1_count;
  logic [SUM_W-1:0]     sum;
  logic [SUM_W-1:0]     sum_total;

  // a last sample in flight still needs a queue slot
  assign need   = {1'b0, job_level} + (LEVEL_W+1)'(s1_valid && s1_last);
  assign full   = (need >= (LEVEL_W+1)'(JOB_DEPTH));
  assign accept = push && !full;

  assign counted = (seen < COUNT_W'(MAX_SAMPLES));
  assign squared = counted && (seen >= COUNT_W'(SKIPPED_SAMPLES));

  assign mag     = sample_value[SAMPLE_W-1] ? (~sample_value + 1'b1) : sample_value;
  assign sq_full = {{MAG_W{1'b0}}, mag} * {{MAG_W{1'b0}}, mag};

  always_comb begin
    seen_next = seen;
    if (accept) begin
      if (last_sample) begin
        seen_next = '0;
      end else if (counted) begin
        seen_next = seen + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seen     <= '0;
      s1_valid <= 1'b0;
      s1_last  <= 1'b0;
    end else begin
      seen     <= seen_next;
      s1_valid <= accept;
      s1_last  <= accept && last_sample;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_sq    <= squared ? sq_full[SQ_W-1:0] : '0;
      s1_count <= counted ? seen + 1'b1 : seen;
    end
  end

  assign sum_total = sum + SUM_W'(s1_sq);

  always_ff @(posedge clk) begin
    if (rst) begin
      sum <= '0;
    end else if (s1_valid) begin
      sum <= s1_last ? '0 : sum_total;
    end
  end

  assign job_wr         = s1_valid && s1_last;
  assign job_data.sum   = sum_total;
  assign job_data.count = s1_count;

`ifndef SYNTHESIS
  a_seen_bounded: assert property (@(posedge clk) disable iff (rst)
    seen <= COUNT_W'(MAX_SAMPLES))
    else $error("sample count above limit");

  a_slot_kept: assert property (@(posedge clk) disable iff (rst)
    (accept && last_sample) |=> (job_level != LEVEL_W'(JOB_DEPTH)))
    else $error("no queue slot for finished block");
`endif

endmodule
`default_nettype wire

// ----- src/rmsb_back.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rmsb_back
// job solver: serial divide by count, serial integer root, result register
// ----------------------------------------------------------------------------
module rmsb_back (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          job_empty,
  input  wire rmsb_pkg::job_t                job_data,
  output logic                               job_rd,
  output logic                               empty,
  input  wire logic                          pop,
  output logic [rmsb_pkg::RMS_W-1:0]         rms_value,
  output logic [rmsb_pkg::COUNT_W-1:0]       sample_count
);
  import rmsb_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_DIV  = 4'b0010,
    ST_SQRT = 4'b0100,
    ST_DONE = 4'b1000
  } state_t;

  state_t               state;
  logic [STEP_W-1:0]    step;
  logic [SUM_W-1:0]     dvd;
  logic [SUM_W-1:0]     dvd_next;
  logic [COUNT_W-1:0]   divisor;
  logic [COUNT_W-1:0]   rem;
  logic [COUNT_W:0]     rem_sh;
  logic                 rem_ge;
  logic [RAD_W-1:0]     rad;
  logic [ROOT_W-1:0]    root;
  logic [SREM_W-1:0]    srem;
  logic [SREM_W+1:0]    srem_sh;
  logic [SREM_W+1:0]    trial;
  logic                 srem_ge;
  logic                 res_valid;
  logic                 res_free;

  assign rem_sh   = {rem, dvd[SUM_W-1]};
  assign rem_ge   = (rem_sh >= {1'b0, divisor});
  assign dvd_next = {dvd[SUM_W-2:0], rem_ge};

  assign srem_sh  = {srem, rad[RAD_W-1 -: 2]};
  assign trial    = (SREM_W+2)'({root, 2'b01});
  assign srem_ge  = (srem_sh >= trial);

  assign res_free = !res_valid || pop;
  assign job_rd   = (state == ST_IDLE) && !job_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      step      <= '0;
      res_valid <= 1'b0;
    end else begin
      if (pop && res_valid) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (!job_empty) begin
            step  <= '0;
            state <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (step == STEP_W'(DIV_STEPS - 1)) begin
            step  <= '0;
            state <= ST_SQRT;
          end else begin
            step <= step + 1'b1;
          end
        end
        ST_SQRT: begin
          if (step == STEP_W'(SQRT_STEPS - 1)) begin
            step  <= '0;
            state <= ST_DONE;
          end else begin
            step <= step + 1'b1;
          end
        end
        ST_DONE: begin
          if (res_free) begin
            res_valid <= 1'b1;
            state     <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        dvd     <= (job_data.count == '0) ? '0 : job_data.sum;
        divisor <= job_data.count;
        rem     <= '0;
      end
      ST_DIV: begin
        dvd <= dvd_next;
        rem <= rem_ge ? COUNT_W'(rem_sh - {1'b0, divisor}) : rem_sh[COUNT_W-1:0];
        if (step == STEP_W'(DIV_STEPS - 1)) begin
          rad  <= dvd_next[RAD_W-1:0];
          root <= '0;
          srem <= '0;
        end
      end
      ST_SQRT: begin
        rad  <= {rad[RAD_W-3:0], 2'b00};
        srem <= srem_ge ? SREM_W'(srem_sh - trial) : srem_sh[SREM_W-1:0];
        root <= {root[ROOT_W-2:0], srem_ge};
      end
      ST_DONE: begin
        if (res_free) begin
          rms_value    <= root[ROOT_W-1] ? {RMS_W{1'b1}} : root[RMS_W-1:0];
          sample_count <= divisor;
        end
      end
      default: begin
      end
    endcase
  end

  assign empty = !res_valid;

`ifndef SYNTHESIS
  a_done_holds: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE && res_valid && !pop) |=> (state == ST_DONE))
    else $error("result register overwritten");
`endif

endmodule
`default_nettype wire
